FILE: src/lcsf_pkg.sv
// lcsf_pkg: shared types, constants and helper functions of the led color sequence fader
// no dependencies; imported by every module of the block
`default_nettype none

package lcsf_pkg;

  localparam int unsigned LCSF_NUM_PIXELS = 8;
  localparam int unsigned LCSF_NUM_STEPS  = 16;

  localparam int unsigned CFG_W = 31;

  localparam logic [4:0]  STEP_COUNT_RST = 5'd1;
  localparam logic [30:0] HOLD_MS_RST    = 31'd0;
  localparam logic [7:0]  FADE_STEP_RST  = 8'd1;
  localparam logic [7:0]  TBRIGHT_RST    = 8'hff;
  localparam logic [31:0] PERIOD_RST     = 32'd10;

  typedef enum logic [1:0] {
    CFG_STEP_COUNT        = 2'd0,
    CFG_HOLD_MS           = 2'd1,
    CFG_FADE_STEP         = 2'd2,
    CFG_TARGET_BRIGHTNESS = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } lcsf_state_e;

  typedef struct packed {
    logic        operation;
    logic [31:0] now_ms;
    logic [2:0]  pixel_sel;
    logic [3:0]  step_sel;
    logic [23:0] entry_color;
    logic [31:0] entry_period_ms;
  } lcsf_in_t;

  typedef struct packed {
    logic [2:0]  pixel_out;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [7:0]  brightness_out;
    logic        updated;
    logic [3:0]  step_out;
    logic [31:0] period_out;
    logic        last;
  } lcsf_out_t;

  typedef struct packed {
    logic [23:0] rgb;
    logic [31:0] hold_start;
    logic        hold_done;
  } pix_st_t;

  typedef struct packed {
    logic       updated;
    logic       done;
    logic [7:0] brightness;
  } calc_res_t;

  typedef struct packed {
    logic [23:0] rgb;
    logic [7:0]  brightness;
    logic        updated;
  } rbuf_t;

  function automatic logic [7:0] approach(input logic [7:0] cur, input logic [7:0] tgt,
                                          input logic [7:0] step);
    logic [7:0] diff;
    logic [7:0] res;
    diff = (cur > tgt) ? (cur - tgt) : (tgt - cur);
    if (diff <= step) begin
      res = tgt;
    end else if (cur < tgt) begin
      res = cur + step;
    end else begin
      res = cur - step;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: src/lcsf_color_mem.sv
// lcsf_color_mem: color table, one 24-bit entry per pixel and step
// depends on lcsf_pkg; cleared by the controller sweeping the write port
`default_nettype none

module lcsf_color_mem
  import lcsf_pkg::*;
#(
  parameter int unsigned NUM_PIXELS = LCSF_NUM_PIXELS,
  parameter int unsigned NUM_STEPS  = LCSF_NUM_STEPS,
  localparam int unsigned DEPTH  = NUM_PIXELS * NUM_STEPS,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire              clk_i,
  input  wire              we_i,
  input  wire [ADDR_W-1:0] waddr_i,
  input  wire [23:0]       wdata_i,
  input  wire              re_i,
  input  wire [ADDR_W-1:0] raddr_i,
  output logic [23:0]      rdata_o
);

  logic [23:0] mem [DEPTH];
  logic [23:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/lcsf_pixel_mem.sv
// lcsf_pixel_mem: per-pixel state (color, hold start, hold flag) with valid bits
// depends on lcsf_pkg; an entry never written reads as zero
`default_nettype none

module lcsf_pixel_mem
  import lcsf_pkg::*;
#(
  parameter int unsigned NUM_PIXELS = LCSF_NUM_PIXELS,
  localparam int unsigned PIX_W = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             we_i,
  input  wire [PIX_W-1:0] waddr_i,
  input  wire pix_st_t    wdata_i,
  input  wire             re_i,
  input  wire [PIX_W-1:0] raddr_i,
  output pix_st_t         rdata_o
);

  pix_st_t                 mem [NUM_PIXELS];
  pix_st_t                 rdata_q;
  logic [NUM_PIXELS-1:0]   vld_q;
  logic                    rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_vld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rdata_q : '0;

endmodule

`default_nettype wire

FILE: src/lcsf_pix_calc.sv
// lcsf_pix_calc: one pixel's fade step, hold timer check and brightness move
// depends on lcsf_pkg (approach function, pixel state and result types)
`default_nettype none

module lcsf_pix_calc
  import lcsf_pkg::*;
(
  input  wire pix_st_t cur_i,
  input  wire [23:0]  tgt_i,
  input  wire [7:0]   bright_i,
  input  wire [7:0]   tbright_i,
  input  wire [7:0]   fade_i,
  input  wire [30:0]  hold_ms_i,
  input  wire [31:0]  now_i,
  output pix_st_t     nxt_o,
  output calc_res_t   res_o
);

  logic [7:0]  r, g, b;
  logic        was_ok;
  logic        reached;
  logic [31:0] elapsed;

  assign was_ok = (cur_i.rgb == tgt_i) && (bright_i == tbright_i);
  assign r = approach(cur_i.rgb[23:16], tgt_i[23:16], fade_i);
  assign g = approach(cur_i.rgb[15:8], tgt_i[15:8], fade_i);
  assign b = approach(cur_i.rgb[7:0], tgt_i[7:0], fade_i);
  assign reached = ({r, g, b} == tgt_i);
  assign elapsed = now_i - cur_i.hold_start;

  always_comb begin
    nxt_o.rgb        = {r, g, b};
    nxt_o.hold_start = cur_i.hold_start;
    nxt_o.hold_done  = cur_i.hold_done;
    res_o.updated    = 1'b1;
    res_o.done       = 1'b0;
    if (reached) begin
      if (elapsed >= {1'b0, hold_ms_i}) begin
        nxt_o.hold_done  = 1'b1;
        nxt_o.hold_start = now_i;
      end
      if (was_ok) begin
        res_o.done    = nxt_o.hold_done;
        res_o.updated = 1'b0;
      end
    end else begin
      nxt_o.hold_done = 1'b0;
    end
    res_o.brightness = bright_i;
    if (res_o.updated) begin
      if (bright_i < tbright_i) begin
        res_o.brightness = bright_i + 8'd1;
      end else if (bright_i > tbright_i) begin
        res_o.brightness = bright_i - 8'd1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/led_color_sequence_fader.sv
// led_color_sequence_fader: top level with control sequencer, period table and result buffer
// depends on lcsf_pkg, lcsf_color_mem, lcsf_pixel_mem, lcsf_pix_calc
// a tick holds busy high after it is taken, for one pixel read-modify-write per
// cycle through the pixel and color memories, then one result beat per cycle from the buffer
// results come out only after every pixel of the tick has been updated
// after reset every entry of the color memory is swept to zero with busy high
// results are strobed for one cycle each and cannot be held off by the receiver
`default_nettype none

module led_color_sequence_fader
  import lcsf_pkg::*;
#(
  parameter int unsigned NUM_PIXELS = LCSF_NUM_PIXELS,
  parameter int unsigned NUM_STEPS  = LCSF_NUM_STEPS
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start_i,
  output logic             busy_o,
  input  wire lcsf_in_t    item_i,
  output logic             result_valid_o,
  output lcsf_out_t        result_o,
  input  wire              cfg_we_i,
  input  wire [1:0]        cfg_idx_i,
  input  wire [CFG_W-1:0]  cfg_wdata_i
);

  localparam int unsigned PIX_W   = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
  localparam int unsigned PCNT_W  = $clog2(NUM_PIXELS + 1);
  localparam int unsigned STEP_W  = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1;
  localparam int unsigned SI_W    = STEP_W + 1;
  localparam int unsigned CDEPTH  = NUM_PIXELS * NUM_STEPS;
  localparam int unsigned CADDR_W = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;

  lcsf_state_e state_q, state_d;

  logic [4:0]  step_count_q;
  logic [30:0] hold_ms_q;
  logic [7:0]  fade_q;
  logic [7:0]  tbright_q;

  logic [CADDR_W-1:0] clr_cnt_q;
  logic [PCNT_W-1:0]  rd_cnt_q;
  logic               proc_vld_q;
  logic [PIX_W-1:0]   proc_pix_q;
  logic               all_done_q;
  logic [31:0]        now_q;
  logic [7:0]         bright_q;
  logic [STEP_W-1:0]  step_idx_q;
  logic [PIX_W-1:0]   em_cnt_q;

  logic out_vld_q;
  logic [2:0] out_pix_q;
  logic out_last_q;

  logic accept;
  logic wr_accept;
  logic tick_accept;
  logic wr_ok;
  logic issue;
  logic last_proc;
  logic em_last;
  logic clr_last;

  logic [STEP_W-1:0] step_nxt;
  logic [SI_W-1:0]   si_inc;
  logic              all_done;

  logic               cm_we;
  logic [CADDR_W-1:0] cm_waddr;
  logic [23:0]        cm_wdata;
  logic [CADDR_W-1:0] cm_raddr;
  logic [23:0]        cm_rdata;

  pix_st_t   pm_rdata;
  pix_st_t   pix_nxt;
  calc_res_t calc_res;

  logic [31:0] per_mem [NUM_STEPS];
  logic [NUM_STEPS-1:0] per_vld_q;
  logic [31:0] per_rd_q;
  logic        per_rd_vld_q;

  rbuf_t rbuf [NUM_PIXELS];
  rbuf_t rbuf_rd_q;

  // control

  assign busy_o      = (state_q != ST_IDLE);
  assign accept      = start_i && !busy_o;
  assign wr_accept   = accept && (item_i.operation == OP_WRITE);
  assign tick_accept = accept && (item_i.operation == OP_TICK);
  assign wr_ok       = ({1'b0, item_i.step_sel} < step_count_q)
                       && (32'(item_i.step_sel) < NUM_STEPS)
                       && (32'(item_i.pixel_sel) < NUM_PIXELS);
  assign issue       = (state_q == ST_RUN) && (rd_cnt_q < PCNT_W'(NUM_PIXELS));
  assign last_proc   = proc_vld_q && (proc_pix_q == PIX_W'(NUM_PIXELS - 1));
  assign em_last     = (em_cnt_q == PIX_W'(NUM_PIXELS - 1));
  assign clr_last    = (clr_cnt_q == CADDR_W'(CDEPTH - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (tick_accept) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_proc) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (em_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_count_q <= STEP_COUNT_RST;
      hold_ms_q    <= HOLD_MS_RST;
      fade_q       <= FADE_STEP_RST;
      tbright_q    <= TBRIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_STEP_COUNT: begin
          if (32'(cfg_wdata_i[4:0]) inside {[1:NUM_STEPS]}) begin
            step_count_q <= cfg_wdata_i[4:0];
          end
        end
        CFG_HOLD_MS:           hold_ms_q <= cfg_wdata_i[30:0];
        CFG_FADE_STEP:         fade_q    <= cfg_wdata_i[7:0];
        CFG_TARGET_BRIGHTNESS: tbright_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // step advance at the end of a tick

  assign all_done = all_done_q && calc_res.done;
  assign si_inc   = SI_W'(step_idx_q) + SI_W'(1);

  always_comb begin
    step_nxt = step_idx_q;
    if (all_done) begin
      if ((si_inc >= SI_W'(NUM_STEPS)) || (32'(si_inc) >= 32'(step_count_q))) begin
        step_nxt = '0;
      end else begin
        step_nxt = si_inc[STEP_W-1:0];
      end
    end
  end

  // sequencer registers

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      rd_cnt_q   <= '0;
      proc_vld_q <= 1'b0;
      proc_pix_q <= '0;
      all_done_q <= 1'b1;
      now_q      <= '0;
      bright_q   <= '0;
      step_idx_q <= '0;
      em_cnt_q   <= '0;
      out_vld_q  <= 1'b0;
      out_pix_q  <= '0;
      out_last_q <= 1'b0;
    end else begin
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + CADDR_W'(1);
      end
      if (tick_accept) begin
        now_q      <= item_i.now_ms;
        rd_cnt_q   <= '0;
        all_done_q <= 1'b1;
        em_cnt_q   <= '0;
      end
      if (issue) begin
        rd_cnt_q <= rd_cnt_q + PCNT_W'(1);
      end
      proc_vld_q <= issue;
      proc_pix_q <= rd_cnt_q[PIX_W-1:0];
      if (proc_vld_q) begin
        all_done_q <= all_done;
        bright_q   <= calc_res.brightness;
      end
      if (last_proc) begin
        step_idx_q <= step_nxt;
      end
      out_vld_q <= (state_q == ST_EMIT);
      if (state_q == ST_EMIT) begin
        em_cnt_q   <= em_cnt_q + PIX_W'(1);
        out_pix_q  <= 3'(em_cnt_q);
        out_last_q <= em_last;
      end
    end
  end

  // color memory, swept to zero after reset

  always_comb begin
    cm_we    = 1'b0;
    cm_waddr = CADDR_W'(item_i.pixel_sel) * CADDR_W'(NUM_STEPS) + CADDR_W'(item_i.step_sel);
    cm_wdata = item_i.entry_color;
    if (state_q == ST_CLEAR) begin
      cm_we    = 1'b1;
      cm_waddr = clr_cnt_q;
      cm_wdata = '0;
    end else if (wr_accept && wr_ok) begin
      cm_we = 1'b1;
    end
  end

  assign cm_raddr = CADDR_W'(rd_cnt_q[PIX_W-1:0]) * CADDR_W'(NUM_STEPS)
                    + CADDR_W'(step_idx_q);

  lcsf_color_mem #(
    .NUM_PIXELS (NUM_PIXELS),
    .NUM_STEPS  (NUM_STEPS)
  ) u_color_mem (
    .clk_i   (clk_i),
    .we_i    (cm_we),
    .waddr_i (cm_waddr),
    .wdata_i (cm_wdata),
    .re_i    (issue),
    .raddr_i (cm_raddr),
    .rdata_o (cm_rdata)
  );

  // pixel state memory; the read of pixel p+1 and the write of pixel p never share an entry

  lcsf_pixel_mem #(
    .NUM_PIXELS (NUM_PIXELS)
  ) u_pixel_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (proc_vld_q),
    .waddr_i (proc_pix_q),
    .wdata_i (pix_nxt),
    .re_i    (issue),
    .raddr_i (rd_cnt_q[PIX_W-1:0]),
    .rdata_o (pm_rdata)
  );

  lcsf_pix_calc u_pix_calc (
    .cur_i     (pm_rdata),
    .tgt_i     (cm_rdata),
    .bright_i  (bright_q),
    .tbright_i (tbright_q),
    .fade_i    (fade_q),
    .hold_ms_i (hold_ms_q),
    .now_i     (now_q),
    .nxt_o     (pix_nxt),
    .res_o     (calc_res)
  );

  // period table

  always_ff @(posedge clk_i) begin
    if (wr_accept && wr_ok) begin
      per_mem[STEP_W'(item_i.step_sel)] <= item_i.entry_period_ms;
    end
    if (last_proc) begin
      per_rd_q <= per_mem[step_nxt];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      per_vld_q    <= '0;
      per_rd_vld_q <= 1'b0;
    end else begin
      if (wr_accept && wr_ok) begin
        per_vld_q[STEP_W'(item_i.step_sel)] <= 1'b1;
      end
      if (last_proc) begin
        per_rd_vld_q <= per_vld_q[step_nxt];
      end
    end
  end

  // result buffer

  always_ff @(posedge clk_i) begin
    if (proc_vld_q) begin
      rbuf[proc_pix_q] <= '{rgb: pix_nxt.rgb, brightness: calc_res.brightness,
                            updated: calc_res.updated};
    end
    if (state_q == ST_EMIT) begin
      rbuf_rd_q <= rbuf[em_cnt_q];
    end
  end

  assign result_valid_o          = out_vld_q;
  assign result_o.pixel_out      = out_pix_q;
  assign result_o.red_out        = rbuf_rd_q.rgb[23:16];
  assign result_o.green_out      = rbuf_rd_q.rgb[15:8];
  assign result_o.blue_out       = rbuf_rd_q.rgb[7:0];
  assign result_o.brightness_out = rbuf_rd_q.brightness;
  assign result_o.updated        = rbuf_rd_q.updated;
  assign result_o.step_out       = 4'(step_idx_q);
  assign result_o.period_out     = per_rd_vld_q ? per_rd_q : PERIOD_RST;
  assign result_o.last           = out_last_q;

`ifndef NO_ASSERTIONS
  a_proc_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_vld_q |-> (state_q == ST_RUN))
    else $error("pixel update outside of a tick");

  a_pixel_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_vld_q && $past(proc_vld_q)) |-> (proc_pix_q == PIX_W'($past(proc_pix_q) + 1'b1)))
    else $error("pixels not walked in order");

  a_step_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_idx_q != $past(step_idx_q)) |-> $past(last_proc))
    else $error("step index moved outside the end of a tick");

  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last) |=> !result_valid_o)
    else $error("result beat right after the last beat of a tick");

  a_emit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (em_cnt_q <= PIX_W'(NUM_PIXELS - 1)))
    else $error("result buffer read beyond the pixel count");
`endif

endmodule

`default_nettype wire

FILE: tb/led_color_sequence_fader_check.sv
// led_color_sequence_fader_check: watches the item, result and register channels of the fader,
// keeps its own copy of the fader state, predicts every result beat and compares field by field
// depends on lcsf_pkg
module led_color_sequence_fader_check
  import lcsf_pkg::*;
(
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start_i,
  input  wire              busy_i,
  input  lcsf_in_t         item_i,
  input  wire              result_valid_i,
  input  lcsf_out_t        result_i,
  input  wire              cfg_we_i,
  input  wire [1:0]        cfg_idx_i,
  input  wire [CFG_W-1:0]  cfg_wdata_i,
  output int unsigned      mismatches_o,
  output int unsigned      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPIX  = LCSF_NUM_PIXELS;
  localparam int NSTEP = LCSF_NUM_STEPS;

  logic [23:0] seq_color [NPIX][NSTEP];
  logic [31:0] seq_period [NSTEP];
  logic [23:0] shade [NPIX];
  logic [31:0] hold_since [NPIX];
  logic        held [NPIX];
  logic [3:0]  cur_step;
  logic [7:0]  glow;

  logic [4:0]  n_steps;
  logic [30:0] min_hold;
  logic [7:0]  fade_rate;
  logic [7:0]  glow_goal;

  lcsf_out_t   frame_q [$];
  int unsigned mism;

  function automatic logic [7:0] move_toward(input logic [7:0] lvl, input logic [7:0] goal,
                                             input logic [7:0] rate);
    int gap;
    gap = int'(goal) - int'(lvl);
    if (gap > int'(rate)) return lvl + rate;
    if (-gap > int'(rate)) return lvl - rate;
    return goal;
  endfunction

  task automatic clear_model();
    int p;
    int s;
    for (p = 0; p < NPIX; p++) begin
      for (s = 0; s < NSTEP; s++) seq_color[p][s] = '0;
      shade[p]      = '0;
      hold_since[p] = '0;
      held[p]       = 1'b0;
    end
    for (s = 0; s < NSTEP; s++) seq_period[s] = PERIOD_RST;
    cur_step  = '0;
    glow      = '0;
    n_steps   = STEP_COUNT_RST;
    min_hold  = HOLD_MS_RST;
    fade_rate = FADE_STEP_RST;
    glow_goal = TBRIGHT_RST;
    frame_q.delete();
    mism = 0;
  endtask

  task automatic write_reg();
    case (cfg_idx_e'(cfg_idx_i))
      CFG_STEP_COUNT: begin
        if (cfg_wdata_i[4:0] >= 5'd1 && cfg_wdata_i[4:0] <= NSTEP) n_steps = cfg_wdata_i[4:0];
      end
      CFG_HOLD_MS:           min_hold  = cfg_wdata_i;
      CFG_FADE_STEP:         fade_rate = cfg_wdata_i[7:0];
      CFG_TARGET_BRIGHTNESS: glow_goal = cfg_wdata_i[7:0];
      default: ;
    endcase
  endtask

  task automatic store_entry(input lcsf_in_t it);
    if (it.step_sel < n_steps) begin
      seq_color[it.pixel_sel][it.step_sel] = it.entry_color;
      seq_period[it.step_sel]              = it.entry_period_ms;
    end
  endtask

  task automatic fade_tick(input logic [31:0] now);
    lcsf_out_t   beat [NPIX];
    logic [23:0] goal;
    logic [23:0] nxt;
    logic        was_ok;
    logic        done;
    logic        shown;
    logic        all_done;
    int          p;
    int          s;
    all_done = 1'b1;
    for (p = 0; p < NPIX; p++) begin
      goal   = seq_color[p][cur_step];
      was_ok = (shade[p] == goal) && (glow == glow_goal);
      nxt = {move_toward(shade[p][23:16], goal[23:16], fade_rate),
             move_toward(shade[p][15:8], goal[15:8], fade_rate),
             move_toward(shade[p][7:0], goal[7:0], fade_rate)};
      shade[p] = nxt;
      done     = 1'b0;
      shown    = 1'b1;
      if (nxt == goal) begin
        if (now - hold_since[p] >= {1'b0, min_hold}) begin
          held[p]       = 1'b1;
          hold_since[p] = now;
        end
        if (was_ok) begin
          done  = held[p];
          shown = 1'b0;
        end
      end else begin
        held[p] = 1'b0;
      end
      if (shown) begin
        if (glow < glow_goal) glow++;
        else if (glow > glow_goal) glow--;
      end
      if (!done) all_done = 1'b0;
      beat[p].pixel_out      = p[2:0];
      beat[p].red_out        = nxt[23:16];
      beat[p].green_out      = nxt[15:8];
      beat[p].blue_out       = nxt[7:0];
      beat[p].brightness_out = glow;
      beat[p].updated        = shown;
      beat[p].last           = (p == NPIX - 1);
    end
    if (all_done) begin
      s = int'(cur_step) + 1;
      if (s >= int'(n_steps)) s = 0;
      cur_step = s[3:0];
    end
    for (p = 0; p < NPIX; p++) begin
      beat[p].step_out   = cur_step;
      beat[p].period_out = seq_period[cur_step];
      frame_q.push_back(beat[p]);
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mism++;
    end
  endtask

  task automatic check_beat(input lcsf_out_t want, input lcsf_out_t got);
    compare_field("pixel_out", want.pixel_out, got.pixel_out);
    compare_field("red_out", want.red_out, got.red_out);
    compare_field("green_out", want.green_out, got.green_out);
    compare_field("blue_out", want.blue_out, got.blue_out);
    compare_field("brightness_out", want.brightness_out, got.brightness_out);
    compare_field("updated", want.updated, got.updated);
    compare_field("step_out", want.step_out, got.step_out);
    compare_field("period_out", want.period_out, got.period_out);
    compare_field("last", want.last, got.last);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_model();
    end else begin
      if (cfg_we_i) write_reg();
      if (result_valid_i) begin
        if (frame_q.size() == 0) begin
          $error("result beat for pixel %0d with nothing expected", result_i.pixel_out);
          mism++;
        end else begin
          check_beat(frame_q.pop_front(), result_i);
        end
      end
      if (start_i && !busy_i) begin
        if (item_i.operation == OP_WRITE) store_entry(item_i);
        else fade_tick(item_i.now_ms);
      end
    end
    mismatches_o <= mism;
    pending_o    <= frame_q.size();
  end

endmodule

FILE: tb/led_color_sequence_fader_test.sv
// led_color_sequence_fader_test: clock, reset, register writes and item stimulus for the fader,
// with a watchdog and the final verdict; checking is done by led_color_sequence_fader_check
// depends on lcsf_pkg, led_color_sequence_fader, led_color_sequence_fader_check
module led_color_sequence_fader_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lcsf_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  lcsf_in_t         item_i = '0;
  logic             cfg_we_i = 1'b0;
  logic [1:0]       cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic             busy_o;
  logic             result_valid_o;
  lcsf_out_t        result_o;

  int unsigned mismatches;
  int unsigned pending;
  int          quiet = 0;
  int          gap_max = 18;
  int          steps_used = 1;
  logic [31:0] clock_ms = '0;

  led_color_sequence_fader u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  led_color_sequence_fader_check u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .item_i         (item_i),
    .result_valid_i (result_valid_o),
    .result_i       (result_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .mismatches_o   (mismatches),
    .pending_o      (pending)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o || cfg_we_i) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic lcsf_in_t tick_item(input logic [31:0] now);
    lcsf_in_t it;
    it.operation       = OP_TICK;
    it.now_ms          = now;
    it.pixel_sel       = 3'($urandom);
    it.step_sel        = 4'($urandom);
    it.entry_color     = 24'($urandom);
    it.entry_period_ms = $urandom;
    return it;
  endfunction

  function automatic lcsf_in_t entry_item(input logic [2:0] pix, input logic [3:0] st,
                                          input logic [23:0] color, input logic [31:0] period);
    lcsf_in_t it;
    it.operation       = OP_WRITE;
    it.now_ms          = $urandom;
    it.pixel_sel       = pix;
    it.step_sel        = st;
    it.entry_color     = color;
    it.entry_period_ms = period;
    return it;
  endfunction

  task automatic send_item(input lcsf_in_t it);
    int gap;
    gap = $urandom_range(gap_max, 0);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= it;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic tick_after(input logic [31:0] dt);
    clock_ms = clock_ms + dt;
    send_item(tick_item(clock_ms));
  endtask

  task automatic settle();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input logic [30:0] sc, input logic [30:0] hold,
                           input logic [30:0] fade, input logic [30:0] goal);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_STEP_COUNT;
    cfg_wdata_i <= sc;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_HOLD_MS;
    cfg_wdata_i <= hold;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_FADE_STEP;
    cfg_wdata_i <= fade;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_TARGET_BRIGHTNESS;
    cfg_wdata_i <= goal;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    if (sc >= 1 && sc <= LCSF_NUM_STEPS) steps_used = sc;
  endtask

  initial begin
    int          ph;
    int          n;
    int          k;
    logic [30:0] sc;
    logic [30:0] hold;
    logic [30:0] fade;
    logic [30:0] goal;
    logic [3:0]  st;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // short directed run: table bounds, timestamp wrap, register extremes
    configure(2, 0, 255, 2);
    send_item(entry_item(3'd0, 4'd0, 24'hFFFFFF, 32'hFFFFFFFF));
    send_item(entry_item(3'd7, 4'd1, 24'h00FF80, 32'h0));
    send_item(entry_item(3'd3, 4'd2, 24'hABCDEF, 32'h12345678));
    send_item(entry_item(3'd5, 4'd15, 24'h5A5A5A, 32'h87654321));
    clock_ms = 32'hFFFFFFF0;
    tick_after(0);
    tick_after(8);
    tick_after(16);
    tick_after(5);
    tick_after(5);
    settle();
    configure(0, 31'h7FFFFFFF, 0, 0);
    send_item(entry_item(3'd2, 4'd1, 24'h010203, 32'hA5A5A5A5));
    tick_after(0);
    tick_after(1000);
    tick_after(32'h80000000);
    settle();
    configure(16, 3, 1, 255);
    send_item(entry_item(3'd7, 4'd15, 24'h000000, 32'h5A5A5A5A));
    send_item(entry_item(3'd1, 4'd8, 24'h808080, 32'hFFFFFFFF));
    tick_after(2);
    tick_after(4);
    tick_after(3);
    settle();
    configure(31, 0, 128, 0);
    tick_after(1);
    tick_after(1);

    for (ph = 0; ph < 6; ph++) begin
      settle();
      gap_max = (ph % 3 == 1) ? 0 : 18;
      k  = $urandom_range(9, 0);
      sc = (k == 0) ? 31'($urandom_range(31, 17)) : (k == 1) ? 31'd0 :
           31'($urandom_range(LCSF_NUM_STEPS, 1));
      k    = $urandom_range(9, 0);
      hold = (k == 0) ? 31'h7FFFFFFF : (k == 1) ? 31'($urandom) : 31'($urandom_range(30, 0));
      k    = $urandom_range(5, 0);
      fade = (k == 0) ? 31'd0 : (k == 1) ? 31'd255 : 31'($urandom_range(128, 1));
      k    = $urandom_range(5, 0);
      goal = (k == 0) ? 31'd255 : (k == 1) ? 31'd0 : 31'($urandom_range(6, 0));
      configure(sc, hold, fade, goal);
      for (n = 0; n < 17; n++) begin
        k = $urandom_range(9, 0);
        if (k < 3) begin
          st = (k == 0) ? 4'($urandom_range(15, 0)) : 4'($urandom_range(steps_used - 1, 0));
          send_item(entry_item(3'($urandom), st, 24'($urandom), $urandom));
        end else if (k == 9) begin
          tick_after($urandom);
        end else begin
          tick_after($urandom_range(25, 0));
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/lcsf_pkg.sv
src/lcsf_color_mem.sv
src/lcsf_pixel_mem.sv
src/lcsf_pix_calc.sv
src/led_color_sequence_fader.sv
tb/led_color_sequence_fader_check.sv
tb/led_color_sequence_fader_test.sv
